/* src/gel_pkg.sv */
// shared types and constants for the gear event logger
`timescale 1ns / 1ps
`default_nettype none

package gel_pkg;

  // default log depth in records
  localparam int LOG_DEPTH_DEF = 10;

  // fixed field widths
  localparam int KEY_W   = 3;
  localparam int DIGIT_W = 8;
  localparam int ADC_W   = 10;
  localparam int IDX_W   = 4;
  localparam int GEAR_W  = 4;
  localparam int SPEED_W = 7;
  localparam int CNT_W   = 4;
  localparam int TIME_W  = 8;

  // item modes
  localparam logic MODE_UPDATE = 1'b0;
  localparam logic MODE_READ   = 1'b1;

  // key codes
  localparam logic [KEY_W-1:0] KEY_COLLISION = 3'd1;
  localparam logic [KEY_W-1:0] KEY_GEAR_UP   = 3'd2;
  localparam logic [KEY_W-1:0] KEY_GEAR_DOWN = 3'd3;

  // gear and event codes
  localparam logic [GEAR_W-1:0] GEAR_LOWEST    = 4'd1;
  localparam logic [GEAR_W-1:0] GEAR_RESUME    = 4'd2;
  localparam logic [GEAR_W-1:0] GEAR_TOP       = 4'd7;
  localparam logic [GEAR_W-1:0] GEAR_COLLISION = 4'd8;

  // ascii code of the digit zero
  localparam logic [DIGIT_W-1:0] ASCII_ZERO = 8'd48;

  // speed = floor(adc * 100 / 1033) as (adc * SPEED_MUL) >> SPEED_SHIFT,
  // SPEED_MUL = 100 * ceil(2^27 / 1033), exact over the whole adc range
  localparam int                SPEED_SHIFT = 27;
  localparam int                PROD_W      = 34;
  localparam logic [PROD_W-1:0] SPEED_MUL   = 34'd12993100;

  // one log record
  typedef struct packed {
    logic [TIME_W-1:0]  hours;
    logic [TIME_W-1:0]  minutes;
    logic [TIME_W-1:0]  seconds;
    logic [GEAR_W-1:0]  event_code;
    logic [SPEED_W-1:0] speed;
  } rec_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DONE
  } ctl_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
  } ctl_cmd_t;

endpackage

`default_nettype wire

/* src/gel_ctrl.sv */
// controller state machine for the gear event logger
`timescale 1ns / 1ps
`default_nettype none

module gel_ctrl (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  wire               out_ready,
  output gel_pkg::ctl_cmd_t cmd
);

  gel_pkg::ctl_state_t state;
  gel_pkg::ctl_state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gel_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    cmd        = '0;
    case (state)
      gel_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = gel_pkg::ST_EXEC;
        end
      end
      gel_pkg::ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = gel_pkg::ST_DONE;
      end
      gel_pkg::ST_DONE: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = gel_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = gel_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* src/gel_datapath.sv */
// datapath of the gear event logger: speed scaling, gear code, record log
`timescale 1ns / 1ps
`default_nettype none

module gel_datapath #(
  parameter int LOG_DEPTH = gel_pkg::LOG_DEPTH_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  input  gel_pkg::ctl_cmd_t                cmd,
  input  wire                              mode,
  input  wire  [gel_pkg::KEY_W-1:0]        key,
  input  wire  [gel_pkg::DIGIT_W-1:0]      hour_tens,
  input  wire  [gel_pkg::DIGIT_W-1:0]      hour_ones,
  input  wire  [gel_pkg::DIGIT_W-1:0]      minute_tens,
  input  wire  [gel_pkg::DIGIT_W-1:0]      minute_ones,
  input  wire  [gel_pkg::DIGIT_W-1:0]      second_tens,
  input  wire  [gel_pkg::DIGIT_W-1:0]      second_ones,
  input  wire  [gel_pkg::ADC_W-1:0]        adc_sample,
  input  wire  [gel_pkg::IDX_W-1:0]        read_index,
  output logic [gel_pkg::GEAR_W-1:0]       gear_code,
  output logic [gel_pkg::SPEED_W-1:0]      speed_now,
  output logic                             logged,
  output logic [gel_pkg::CNT_W-1:0]        entry_count,
  output logic                             rd_valid,
  output logic [gel_pkg::TIME_W-1:0]       rd_hours,
  output logic [gel_pkg::TIME_W-1:0]       rd_minutes,
  output logic [gel_pkg::TIME_W-1:0]       rd_seconds,
  output logic [gel_pkg::GEAR_W-1:0]       rd_event,
  output logic [gel_pkg::SPEED_W-1:0]      rd_speed
);

  localparam int PTR_W = $clog2(LOG_DEPTH);
  localparam int SUM_W = PTR_W + 1;
  localparam logic [SUM_W-1:0]           DEPTH_S = SUM_W'(LOG_DEPTH);
  localparam logic [gel_pkg::CNT_W-1:0]  DEPTH_C = gel_pkg::CNT_W'(LOG_DEPTH);
  localparam logic [PTR_W-1:0]           LAST_P  = PTR_W'(LOG_DEPTH - 1);

  // ascii digit pair to a value, wrapping at 8 bits
  function automatic logic [gel_pkg::TIME_W-1:0] time_part(
    input logic [gel_pkg::DIGIT_W-1:0] tens,
    input logic [gel_pkg::DIGIT_W-1:0] ones
  );
    logic [gel_pkg::TIME_W-1:0] t;
    logic [gel_pkg::TIME_W-1:0] o;
    t = tens - gel_pkg::ASCII_ZERO;
    o = ones - gel_pkg::ASCII_ZERO;
    return gel_pkg::TIME_W'(t * 8'd10) + o;
  endfunction

  // reduce a sum below twice the depth to a log slot
  function automatic logic [PTR_W-1:0] wrap_slot(input logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] r;
    r = (s >= DEPTH_S) ? s - DEPTH_S : s;
    return r[PTR_W-1:0];
  endfunction

  // captured request
  logic                          mode_q;
  logic [gel_pkg::KEY_W-1:0]     key_q;
  logic [gel_pkg::DIGIT_W-1:0]   ht_q, ho_q, mt_q, mo_q, st_q, so_q;
  logic [gel_pkg::ADC_W-1:0]     adc_q;
  logic [gel_pkg::IDX_W-1:0]     idx_q;

  // architectural state
  logic [gel_pkg::GEAR_W-1:0]    gear;
  logic [gel_pkg::SPEED_W-1:0]   speed;
  logic [gel_pkg::CNT_W-1:0]     count;
  logic [PTR_W-1:0]              head;

  // result registers
  logic                          logged_r;
  logic                          rd_valid_r;
  gel_pkg::rec_t                 rd_rec;

  // record memory
  gel_pkg::rec_t                 mem [LOG_DEPTH];

  logic [gel_pkg::PROD_W-1:0]    prod;
  logic [gel_pkg::SPEED_W-1:0]   speed_calc;
  logic [gel_pkg::GEAR_W-1:0]    gear_calc;
  logic                          log_hit;
  logic                          full;
  logic                          rd_hit;
  logic [PTR_W-1:0]              wr_addr;
  logic [PTR_W-1:0]              rd_addr;
  logic [PTR_W-1:0]              head_inc;
  gel_pkg::rec_t                 wr_rec;

  // capture the request on accept
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q <= mode;
      key_q  <= key;
      ht_q   <= hour_tens;
      ho_q   <= hour_ones;
      mt_q   <= minute_tens;
      mo_q   <= minute_ones;
      st_q   <= second_tens;
      so_q   <= second_ones;
      adc_q  <= adc_sample;
      idx_q  <= read_index;
    end
  end

  // speed scaling by reciprocal multiply
  assign prod       = gel_pkg::PROD_W'(adc_q) * gel_pkg::SPEED_MUL;
  assign speed_calc = prod[gel_pkg::SPEED_SHIFT +: gel_pkg::SPEED_W];

  // gear code update and record decision
  always_comb begin
    gear_calc = gear;
    log_hit   = 1'b0;
    case (key_q)
      gel_pkg::KEY_GEAR_UP: begin
        log_hit = 1'b1;
        if (gear == gel_pkg::GEAR_COLLISION) begin
          gear_calc = gel_pkg::GEAR_RESUME;
        end else if (gear < gel_pkg::GEAR_TOP) begin
          gear_calc = gear + 4'd1;
        end
      end
      gel_pkg::KEY_GEAR_DOWN: begin
        log_hit = 1'b1;
        if (gear == gel_pkg::GEAR_COLLISION) begin
          gear_calc = gel_pkg::GEAR_RESUME;
        end else if (gear > gel_pkg::GEAR_LOWEST) begin
          gear_calc = gear - 4'd1;
        end
      end
      gel_pkg::KEY_COLLISION: begin
        log_hit   = 1'b1;
        gear_calc = gel_pkg::GEAR_COLLISION;
      end
      default: begin
        log_hit = 1'b0;
      end
    endcase
  end

  // ring addressing
  assign full     = (count == DEPTH_C);
  assign head_inc = (head == LAST_P) ? '0 : head + PTR_W'(1);
  assign wr_addr  = full ? head
                  : wrap_slot({1'b0, head} + {1'b0, count[PTR_W-1:0]});
  assign rd_hit   = (idx_q < count);
  assign rd_addr  = wrap_slot({1'b0, head} + {1'b0, idx_q[PTR_W-1:0]});

  // record to append
  always_comb begin
    wr_rec.hours      = time_part(ht_q, ho_q);
    wr_rec.minutes    = time_part(mt_q, mo_q);
    wr_rec.seconds    = time_part(st_q, so_q);
    wr_rec.event_code = gear_calc;
    wr_rec.speed      = speed_calc;
  end

  // state and result update
  always_ff @(posedge clk) begin
    if (rst) begin
      gear       <= '0;
      speed      <= '0;
      count      <= '0;
      head       <= '0;
      logged_r   <= 1'b0;
      rd_valid_r <= 1'b0;
    end else if (cmd.exec) begin
      if (mode_q == gel_pkg::MODE_UPDATE) begin
        speed      <= speed_calc;
        gear       <= gear_calc;
        logged_r   <= log_hit;
        rd_valid_r <= 1'b0;
        if (log_hit) begin
          if (full) begin
            head <= head_inc;
          end else begin
            count <= count + 4'd1;
          end
        end
      end else begin
        logged_r   <= 1'b0;
        rd_valid_r <= rd_hit;
      end
    end
  end

  // memory write port
  always_ff @(posedge clk) begin
    if (cmd.exec && mode_q == gel_pkg::MODE_UPDATE && log_hit) begin
      mem[wr_addr] <= wr_rec;
    end
  end

  // memory read port, registered
  always_ff @(posedge clk) begin
    if (cmd.exec && mode_q == gel_pkg::MODE_READ && rd_hit) begin
      rd_rec <= mem[rd_addr];
    end
  end

  // result fields
  assign gear_code   = gear;
  assign speed_now   = speed;
  assign logged      = logged_r;
  assign entry_count = count;
  assign rd_valid    = rd_valid_r;
  assign rd_hours    = rd_valid_r ? rd_rec.hours      : '0;
  assign rd_minutes  = rd_valid_r ? rd_rec.minutes    : '0;
  assign rd_seconds  = rd_valid_r ? rd_rec.seconds    : '0;
  assign rd_event    = rd_valid_r ? rd_rec.event_code : '0;
  assign rd_speed    = rd_valid_r ? rd_rec.speed      : '0;

endmodule

`default_nettype wire

/* src/gear_event_logger_unit.sv */
// top level of the gear event logger
//
//   channel | signals              | payload
//   input   | in_valid, in_ready   | mode, key, time digits, adc_sample, read_index
//   output  | out_valid, out_ready | gear_code, speed_now, logged, entry_count, rd_*
//
// one request at a time: accept, execute, then the result is shown;
// in_ready rises again the cycle after the result is taken
// the execute state does the speed multiply, gear update and one log access
// synchronous reset clears gear, speed, count and head; log memory is not cleared
// a stalled result simply holds in state until out_ready
`timescale 1ns / 1ps
`default_nettype none

module gear_event_logger_unit #(
  parameter int LOG_DEPTH = gel_pkg::LOG_DEPTH_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire                              mode,
  input  wire  [gel_pkg::KEY_W-1:0]        key,
  input  wire  [gel_pkg::DIGIT_W-1:0]      hour_tens,
  input  wire  [gel_pkg::DIGIT_W-1:0]      hour_ones,
  input  wire  [gel_pkg::DIGIT_W-1:0]      minute_tens,
  input  wire  [gel_pkg::DIGIT_W-1:0]      minute_ones,
  input  wire  [gel_pkg::DIGIT_W-1:0]      second_tens,
  input  wire  [gel_pkg::DIGIT_W-1:0]      second_ones,
  input  wire  [gel_pkg::ADC_W-1:0]        adc_sample,
  input  wire  [gel_pkg::IDX_W-1:0]        read_index,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [gel_pkg::GEAR_W-1:0]       gear_code,
  output logic [gel_pkg::SPEED_W-1:0]      speed_now,
  output logic                             logged,
  output logic [gel_pkg::CNT_W-1:0]        entry_count,
  output logic                             rd_valid,
  output logic [gel_pkg::TIME_W-1:0]       rd_hours,
  output logic [gel_pkg::TIME_W-1:0]       rd_minutes,
  output logic [gel_pkg::TIME_W-1:0]       rd_seconds,
  output logic [gel_pkg::GEAR_W-1:0]       rd_event,
  output logic [gel_pkg::SPEED_W-1:0]      rd_speed
);

  gel_pkg::ctl_cmd_t cmd;

  // sequencer
  gel_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // datapath and log memory
  gel_datapath #(
    .LOG_DEPTH (LOG_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .mode        (mode),
    .key         (key),
    .hour_tens   (hour_tens),
    .hour_ones   (hour_ones),
    .minute_tens (minute_tens),
    .minute_ones (minute_ones),
    .second_tens (second_tens),
    .second_ones (second_ones),
    .adc_sample  (adc_sample),
    .read_index  (read_index),
    .gear_code   (gear_code),
    .speed_now   (speed_now),
    .logged      (logged),
    .entry_count (entry_count),
    .rd_valid    (rd_valid),
    .rd_hours    (rd_hours),
    .rd_minutes  (rd_minutes),
    .rd_seconds  (rd_seconds),
    .rd_event    (rd_event),
    .rd_speed    (rd_speed)
  );

`ifndef ASSERT_OFF
  // no new request is taken while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("in_ready and out_valid high together");

  // an accepted request passes through the execute state, then its result is shown
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready ##1 out_valid)
    else $error("result not shown after execute cycle");

  // log count never exceeds the depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= gel_pkg::CNT_W'(LOG_DEPTH))
    else $error("entry_count beyond log depth");

  // a logged update leaves a non-empty log and never carries read data
  a_logged: assert property (@(posedge clk) disable iff (rst)
    (out_valid && logged) |-> (entry_count != '0 && !rd_valid))
    else $error("logged result inconsistent");
`endif

endmodule

`default_nettype wire
